// ----- src/jst_pkg.sv -----
// ----------------------------------------------------------------------------
// jst_pkg
// Shared types and constants of the journal stream tracker: event codes,
// result beat layout, slot update command and the cell chain link.
// ----------------------------------------------------------------------------
package jst_pkg;

    localparam int WORD_W = 32;
    localparam int SLOT_FIELD_W = 4;

    typedef enum logic [3:0] {
        EV_NONE        = 4'd0,
        EV_START       = 4'd1,
        EV_APPEND      = 4'd2,
        EV_END         = 4'd3,
        EV_ABORT       = 4'd4,
        EV_BADSEQ      = 4'd5,
        EV_INFO_IGN    = 4'd6,
        EV_DATA_ORPHAN = 4'd7,
        EV_END_ORPHAN  = 4'd8,
        EV_HALT        = 4'd9,
        EV_FULL        = 4'd10
    } event_t;

    typedef enum logic [1:0] {
        UPD_NONE  = 2'd0,
        UPD_CLEAR = 2'd1,
        UPD_LOAD  = 2'd2,
        UPD_WRITE = 2'd3
    } upd_op_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_DECIDE = 1'b1
    } state_t;

    typedef struct packed {
        event_t                  event_res;
        logic [SLOT_FIELD_W-1:0] slot;
        logic [WORD_W-1:0]       stream_offset;
        logic [WORD_W-1:0]       event_stream;
        logic                    last;
    } res_t;

    typedef struct packed {
        upd_op_t           op;
        logic [WORD_W-1:0] stream;
        logic [WORD_W-1:0] next_record;
        logic [WORD_W-1:0] offset;
    } upd_t;

    typedef struct packed {
        logic hit_seen;
        logic free_seen;
    } chain_t;

endpackage

// ----- src/journal_stream_tracker.sv -----
// ----------------------------------------------------------------------------
// journal_stream_tracker
// Tracks open journal streams from a sequence of record headers.
//
// s_ channel: one record header per beat; tuser carries the type flags,
// tdata the numbers. m_ channel: one or two event beats per record, tlast
// on the final one. cfg_we/cfg_wdata load the expected global number of
// the first record and may only be used while no record is in flight.
// A record is taken in the idle state and resolved in the decide state once
// the result queue has room, so the block takes no new record until the last
// one is resolved; the first event beat is registered in the result queue
// before it is valid on m_. The lookup across the row of slot cells is
// registered on acceptance and resolved by the priority chain and the update
// in the decide state.
// A two-beat queue holds finished events; while m_tready is low the block
// still takes the next record and resolves it once the queue has room.
// Reset empties the table, clears the halt flag and sets the expected
// global number to zero; the table itself needs no clearing pass.
// ----------------------------------------------------------------------------
module journal_stream_tracker #(
    parameter int STREAM_SLOTS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,    // first_global_number
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [159:0] s_tdata,      // global_number, stream_id, record_number,
                                       // record_length, open_offset
    input  logic [3:0]   s_tuser,      // is_abort, is_info, is_data, is_end
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [71:0]  m_tdata,      // event_res, slot, stream_offset, event_stream
    output logic         m_tlast
);
    import jst_pkg::*;

    localparam int SLOT_W = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;

    state_t            state_reg, state_next;
    logic [WORD_W-1:0] counter_reg;
    logic              halted_reg;

    logic              abort_reg, info_reg, data_reg, end_reg;
    logic [WORD_W-1:0] gnum_reg, sid_reg, rnum_reg, rlen_reg, soff_reg;

    logic              accept;
    logic              advance;
    logic              room;
    logic              gl_bad;

    chain_t            chain [STREAM_SLOTS+1];
    logic [STREAM_SLOTS-1:0] sel_hit, sel_free;
    logic [WORD_W-1:0] cell_offset [STREAM_SLOTS];
    logic [WORD_W-1:0] cell_next   [STREAM_SLOTS];

    logic              hit, has_free;
    logic [SLOT_W-1:0] hidx, fidx;
    logic [SLOT_W+3:0] hidx_ext, fidx_ext;
    logic [WORD_W-1:0] hoff, hnext, sum_off;

    res_t              res0, res1, head;
    logic              two;
    upd_t              upd, upd_dec;
    logic [1:0]        q_count;
    logic              pop;

    // input register
    assign accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (accept) begin
            abort_reg <= s_tuser[0];
            info_reg  <= s_tuser[1];
            data_reg  <= s_tuser[2];
            end_reg   <= s_tuser[3];
            gnum_reg  <= s_tdata[31:0];
            sid_reg   <= s_tdata[63:32];
            rnum_reg  <= s_tdata[95:64];
            rlen_reg  <= s_tdata[127:96];
            soff_reg  <= s_tdata[159:128];
        end
    end

    // slot cells
    assign chain[0] = '0;

    for (genvar i = 0; i < STREAM_SLOTS; i++) begin : g_cell
        jst_cell u_cell (
            .aclk         (aclk),
            .aresetn      (aresetn),
            .lookup_en    (accept),
            .query_stream (s_tdata[63:32]),
            .upd          (upd),
            .chain_in     (chain[i]),
            .chain_out    (chain[i+1]),
            .sel_hit      (sel_hit[i]),
            .sel_free     (sel_free[i]),
            .offset       (cell_offset[i]),
            .next_record  (cell_next[i])
        );
    end

    always_comb begin
        hidx  = '0;
        fidx  = '0;
        hoff  = '0;
        hnext = '0;
        for (int i = 0; i < STREAM_SLOTS; i++) begin
            if (sel_hit[i]) begin
                hidx  = hidx | SLOT_W'(i);
                hoff  = hoff | cell_offset[i];
                hnext = hnext | cell_next[i];
            end
            if (sel_free[i]) fidx = fidx | SLOT_W'(i);
        end
    end

    assign hit      = chain[STREAM_SLOTS].hit_seen;
    assign has_free = chain[STREAM_SLOTS].free_seen;
    assign hidx_ext = {4'b0, hidx};
    assign fidx_ext = {4'b0, fidx};
    assign sum_off  = hoff + rlen_reg;
    assign gl_bad   = halted_reg || (gnum_reg != counter_reg);

    // decision
    always_comb begin
        res0 = '{event_res: EV_NONE, slot: '0, stream_offset: '0,
                 event_stream: sid_reg, last: 1'b1};
        res1 = res0;
        two  = 1'b0;
        upd_dec = '{op: UPD_NONE, stream: sid_reg, next_record: rnum_reg,
                    offset: soff_reg};
        priority if (gl_bad) begin
            res0.event_res = EV_HALT;
        end else if (hit && hnext != rnum_reg) begin
            res0.event_res     = EV_BADSEQ;
            res0.slot          = hidx_ext[3:0];
            res0.stream_offset = hoff;
            upd_dec.op         = UPD_CLEAR;
        end else if (abort_reg) begin
            if (hit) begin
                res0.event_res     = EV_ABORT;
                res0.slot          = hidx_ext[3:0];
                res0.stream_offset = hoff;
                upd_dec.op         = UPD_CLEAR;
            end
        end else if (info_reg) begin
            priority if (hit) begin
                res0.event_res     = EV_INFO_IGN;
                res0.slot          = hidx_ext[3:0];
                res0.stream_offset = hoff;
            end else if (has_free) begin
                res0.event_res     = EV_START;
                res0.slot          = fidx_ext[3:0];
                res0.stream_offset = soff_reg;
                upd_dec.op         = UPD_LOAD;
            end else begin
                res0.event_res = EV_FULL;
            end
        end else begin
            if (hit) begin
                res0.slot          = hidx_ext[3:0];
                res0.stream_offset = hoff;
            end
            priority if (data_reg && end_reg) begin
                two       = 1'b1;
                res0.last = 1'b0;
                if (hit) begin
                    res0.event_res     = EV_APPEND;
                    res1.event_res     = EV_END;
                    res1.slot          = hidx_ext[3:0];
                    res1.stream_offset = sum_off;
                    upd_dec.op         = UPD_CLEAR;
                end else begin
                    res0.event_res = EV_DATA_ORPHAN;
                    res1.event_res = EV_END_ORPHAN;
                end
            end else if (data_reg) begin
                if (hit) begin
                    res0.event_res      = EV_APPEND;
                    upd_dec.op          = UPD_WRITE;
                    upd_dec.offset      = sum_off;
                    upd_dec.next_record = hnext + 32'd1;
                end else begin
                    res0.event_res = EV_DATA_ORPHAN;
                end
            end else if (end_reg) begin
                if (hit) begin
                    res0.event_res = EV_END;
                    upd_dec.op     = UPD_CLEAR;
                end else begin
                    res0.event_res = EV_END_ORPHAN;
                end
            end else begin
                res0.event_res = EV_NONE;
            end
        end
    end

    assign room = two ? (q_count == 2'd0) : (q_count != 2'd2);

    // control
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_DECIDE;
            ST_DECIDE: if (room) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready = 1'b0;
        advance  = 1'b0;
        unique case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_DECIDE: advance  = room;
            default: ;
        endcase
    end

    always_comb begin
        upd = upd_dec;
        if (!advance) upd.op = UPD_NONE;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            counter_reg <= '0;
            halted_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                counter_reg <= cfg_wdata;
            end else if (advance) begin
                if (gl_bad) halted_reg <= 1'b1;
                else counter_reg <= counter_reg + 32'd1;
            end
        end
    end

    // result queue
    assign pop = m_tvalid && m_tready;

    jst_outq u_outq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (advance),
        .push_two (two),
        .res0     (res0),
        .res1     (res1),
        .pop      (pop),
        .head     (head),
        .count    (q_count)
    );

    assign m_tvalid = (q_count != 2'd0);
    assign m_tdata  = {head.event_stream, head.stream_offset, head.slot, head.event_res};
    assign m_tlast  = head.last;

    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halt flag cleared without reset");

    a_halt_no_update: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> upd.op == UPD_NONE)
        else $error("table updated while halted");

    a_one_hit: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(sel_hit) && $onehot0(sel_free))
        else $error("more than one slot selected");

    a_accept_then_decide: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_DECIDE && !s_tready)
        else $error("record not resolved after acceptance");

endmodule

// ----- src/jst_cell.sv -----
// ----------------------------------------------------------------------------
// jst_cell
// One stream table entry. Compares its stream number on each accepted beat,
// claims the lowest hit or free position along the chain, and applies the
// update command when it is the selected entry.
// ----------------------------------------------------------------------------
module jst_cell (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       lookup_en,
    input  logic [jst_pkg::WORD_W-1:0] query_stream,
    input  jst_pkg::upd_t              upd,
    input  jst_pkg::chain_t            chain_in,
    output jst_pkg::chain_t            chain_out,
    output logic                       sel_hit,
    output logic                       sel_free,
    output logic [jst_pkg::WORD_W-1:0] offset,
    output logic [jst_pkg::WORD_W-1:0] next_record
);
    import jst_pkg::*;

    logic              valid_reg;
    logic [WORD_W-1:0] stream_reg;
    logic [WORD_W-1:0] next_record_reg;
    logic [WORD_W-1:0] offset_reg;
    logic              match_reg;
    logic              free_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            match_reg <= 1'b0;
            free_reg  <= 1'b0;
        end else if (lookup_en) begin
            match_reg <= valid_reg && (stream_reg == query_stream);
            free_reg  <= !valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            unique case (upd.op)
                UPD_CLEAR: if (sel_hit) valid_reg <= 1'b0;
                UPD_LOAD:  if (sel_free) valid_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (upd.op == UPD_LOAD && sel_free) begin
            stream_reg      <= upd.stream;
            next_record_reg <= upd.next_record;
            offset_reg      <= upd.offset;
        end else if (upd.op == UPD_WRITE && sel_hit) begin
            next_record_reg <= upd.next_record;
            offset_reg      <= upd.offset;
        end
    end

    assign sel_hit             = match_reg && !chain_in.hit_seen;
    assign sel_free            = free_reg && !chain_in.free_seen;
    assign chain_out.hit_seen  = chain_in.hit_seen || match_reg;
    assign chain_out.free_seen = chain_in.free_seen || free_reg;
    assign offset              = offset_reg;
    assign next_record         = next_record_reg;

endmodule

// ----- src/jst_outq.sv -----
// ----------------------------------------------------------------------------
// jst_outq
// Two-entry result queue between the decision stage and the master side.
// Takes one or two results at a time and hands out one beat per handshake.
// ----------------------------------------------------------------------------
module jst_outq (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  logic          push_two,
    input  jst_pkg::res_t res0,
    input  jst_pkg::res_t res1,
    input  logic          pop,
    output jst_pkg::res_t head,
    output logic [1:0]    count
);
    import jst_pkg::*;

    res_t       q0_reg, q0_next;
    res_t       q1_reg, q1_next;
    logic [1:0] count_reg, count_next;
    logic [1:0] count_mid;

    always_comb begin
        q0_next   = q0_reg;
        q1_next   = q1_reg;
        count_mid = count_reg;
        if (pop) begin
            q0_next   = q1_reg;
            count_mid = count_reg - 2'd1;
        end
        count_next = count_mid;
        if (push) begin
            unique case (count_mid)
                2'd0: begin
                    q0_next = res0;
                    if (push_two) q1_next = res1;
                end
                2'd1: q1_next = res0;
                default: ;
            endcase
            count_next = count_mid + (push_two ? 2'd2 : 2'd1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

    assign head  = q0_reg;
    assign count = count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg != 2'd3)
        else $error("result queue over capacity");

    a_pop_needs_data: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != 2'd0)
        else $error("pop from empty result queue");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && push_two) |-> count_reg == 2'd0)
        else $error("double push without room");

endmodule
